// File: design/pwlq_pkg.sv
// Shared types and constants for the piecewise linear quantile evaluator.
`default_nettype none

package pwlq_pkg;

  // Field widths
  localparam int unsigned QW      = 18;  // quantile, signed Q2.16
  localparam int unsigned VW      = 32;  // data value, signed Q16.16
  localparam int unsigned IDXW    = 6;   // knot index on the load word
  localparam int unsigned CNTW    = 7;   // knot count and search position
  localparam int unsigned PRODW   = VW + QW + 2;  // (dq) * (dx) product
  localparam int unsigned DVDW    = VW + QW;      // rounded dividend magnitude

  // Divider: one quotient bit per cycle
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned DIV_CNTW  = 5;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } op_e;

  // Read address source for the knot memory
  typedef enum logic [1:0] {
    RD_ZERO,
    RD_LAST,
    RD_JD_M1,
    RD_JD
  } rd_sel_e;

  // Search index update
  typedef enum logic [1:0] {
    J_HOLD,
    J_CLAMP,
    J_DEC,
    J_INC
  } j_op_e;

  // Result register load
  typedef enum logic [2:0] {
    RES_NONE,
    RES_MISS,
    RES_RDATA,
    RES_FAIL,
    RES_LO,
    RES_DIV
  } res_op_e;

  typedef struct packed {
    logic signed [QW-1:0] quantile;
    logic signed [VW-1:0] value;
  } knot_t;

  // Controller to datapath
  typedef struct packed {
    logic    mem_wr;
    logic    query_load;
    rd_sel_e rd_sel;
    j_op_e   j_op;
    logic    pos_load;
    logic    lo_load;
    logic    seg_load;
    logic    mul_load;
    logic    div_init;
    logic    div_step;
    res_op_e res_op;
    logic    out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic q_le;      // query <= quantile read
    logic q_lt;      // query <  quantile read
    logic j_one;     // search index is 1
    logic j_last;    // search index is count - 1
    logic den_pos;   // segment width is positive
    logic out_free;  // output register can take a word
  } stat_t;

endpackage

`default_nettype wire

// File: design/piecewise_linear_quantile_eval.sv
// Top level of the piecewise linear quantile evaluator.
//
//  channel  | direction | handshake               | word
//  ---------+-----------+-------------------------+-----------------------------------
//  in       | input     | in_valid_i / in_stall_o  | opcode, knot fields, query fields
//  out      | output    | out_valid_o / out_stall_i| result_value, result_missing, status
//  cfg      | input     | cfg_we_i                | knot_count (cfg_wdata_i)
//
// A load word never holds the input; an evaluate word holds it until its result
// enters the output register: directly when missing, after the end-knot checks
// when clamped, and after each search step, multiply and divide when interpolated.
// The output register lets the next word enter while a result waits.
// Reset: knot count 2, search position 1; knot memory is not cleared.
`default_nettype none

module piecewise_linear_quantile_eval
  import pwlq_pkg::*;
#(
  parameter int unsigned MAX_KNOTS = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CNTW-1:0]      cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 opcode_i,
  input  logic [IDXW-1:0]      knot_index_i,
  input  logic signed [VW-1:0] knot_value_i,
  input  logic signed [QW-1:0] knot_quantile_i,
  input  logic signed [QW-1:0] query_quantile_i,
  input  logic                 query_missing_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [VW-1:0] result_value_o,
  output logic                 result_missing_o,
  output logic                 status_o
);

  cmd_t  cmd;
  stat_t stat;
  logic  busy;

  assign in_stall_o = busy;

  pwlq_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .opcode_i        (opcode_i),
    .query_missing_i (query_missing_i),
    .stat_i          (stat),
    .cmd_o           (cmd),
    .busy_o          (busy)
  );

  pwlq_dpath #(
    .MAX_KNOTS (MAX_KNOTS)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .knot_index_i     (knot_index_i),
    .knot_value_i     (knot_value_i),
    .knot_quantile_i  (knot_quantile_i),
    .query_quantile_i (query_quantile_i),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .result_value_o   (result_value_o),
    .result_missing_o (result_missing_o),
    .status_o         (status_o)
  );

`ifndef SYNTHESIS
  // An evaluate word always occupies the block past its accept cycle
  a_eval_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (opcode_i == OP_EVAL) |=> in_stall_o)
    else $error("evaluate word did not start a sequence");

  // A load word completes in its accept cycle
  a_load_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (opcode_i == OP_LOAD) |=> !in_stall_o)
    else $error("load word held the input");

  // A missing query never reports a placement failure
  a_miss_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_missing_o |-> !status_o)
    else $error("missing result flagged with error status");

  // A result is loaded only when the output register can take it
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> stat.out_free)
    else $error("output register overwritten");
`endif

endmodule

`default_nettype wire

// File: design/pwlq_ctrl.sv
// Controller: sequences search, multiply, divide and result hand-off.
`default_nettype none

module pwlq_ctrl
  import pwlq_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  logic  opcode_i,
  input  logic  query_missing_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o,
  output logic  busy_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIRST,
    S_LAST,
    S_BACK,
    S_FWD,
    S_MUL,
    S_INIT,
    S_DIV,
    S_FIX,
    S_OUT
  } state_e;

  state_e              state_q, state_d;
  logic [DIV_CNTW-1:0] cnt_q, cnt_d;

  assign busy_o = (state_q != S_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.rd_sel = RD_ZERO;
    cmd_o.j_op   = J_HOLD;
    cmd_o.res_op = RES_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (opcode_i == OP_EVAL) begin
            cmd_o.query_load = 1'b1;
            if (query_missing_i) begin
              cmd_o.res_op = RES_MISS;
              state_d      = S_OUT;
            end else begin
              state_d = S_FIRST;
            end
          end else begin
            cmd_o.mem_wr = 1'b1;
          end
        end
      end
      // knot 0 on the read port
      S_FIRST: begin
        if (stat_i.q_le) begin
          cmd_o.res_op = RES_RDATA;
          state_d      = S_OUT;
        end else begin
          cmd_o.rd_sel = RD_LAST;
          state_d      = S_LAST;
        end
      end
      // last knot on the read port
      S_LAST: begin
        if (!stat_i.q_lt) begin
          cmd_o.res_op = RES_RDATA;
          state_d      = S_OUT;
        end else begin
          cmd_o.j_op   = J_CLAMP;
          cmd_o.rd_sel = RD_JD_M1;
          state_d      = S_BACK;
        end
      end
      // knot j-1 on the read port: step back while query lies below it
      S_BACK: begin
        if (stat_i.q_lt) begin
          cmd_o.j_op = J_DEC;
          if (stat_i.j_one) begin
            cmd_o.pos_load = 1'b1;
            cmd_o.res_op   = RES_FAIL;
            state_d        = S_OUT;
          end else begin
            cmd_o.rd_sel = RD_JD_M1;
          end
        end else begin
          cmd_o.lo_load = 1'b1;
          cmd_o.rd_sel  = RD_JD;
          state_d       = S_FWD;
        end
      end
      // knot j on the read port: step forward while it lies below query
      S_FWD: begin
        if (!stat_i.q_le) begin
          cmd_o.j_op = J_INC;
          if (stat_i.j_last) begin
            cmd_o.pos_load = 1'b1;
            cmd_o.res_op   = RES_FAIL;
            state_d        = S_OUT;
          end else begin
            cmd_o.lo_load = 1'b1;
            cmd_o.rd_sel  = RD_JD;
          end
        end else begin
          cmd_o.pos_load = 1'b1;
          cmd_o.seg_load = 1'b1;
          if (stat_i.den_pos) begin
            state_d = S_MUL;
          end else begin
            cmd_o.res_op = RES_LO;
            state_d      = S_OUT;
          end
        end
      end
      S_MUL: begin
        cmd_o.mul_load = 1'b1;
        state_d        = S_INIT;
      end
      S_INIT: begin
        cmd_o.div_init = 1'b1;
        cnt_d          = DIV_CNTW'(DIV_STEPS - 1);
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = S_FIX;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_FIX: begin
        cmd_o.res_op = RES_DIV;
        state_d      = S_OUT;
      end
      S_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// File: design/pwlq_dpath.sv
// Datapath: knot memory, search index, multiplier, divider, output register.
`default_nettype none

module pwlq_dpath
  import pwlq_pkg::*;
#(
  parameter int unsigned MAX_KNOTS = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cmd_t                   cmd_i,
  output stat_t                  stat_o,
  input  logic                   cfg_we_i,
  input  logic [CNTW-1:0]        cfg_wdata_i,
  input  logic [IDXW-1:0]        knot_index_i,
  input  logic signed [VW-1:0]   knot_value_i,
  input  logic signed [QW-1:0]   knot_quantile_i,
  input  logic signed [QW-1:0]   query_quantile_i,
  input  logic                   out_stall_i,
  output logic                   out_valid_o,
  output logic signed [VW-1:0]   result_value_o,
  output logic                   result_missing_o,
  output logic                   status_o
);

  localparam int unsigned AW = $clog2(MAX_KNOTS);

  // Knot memory: one write, one registered read
  knot_t          mem [MAX_KNOTS];
  knot_t          rdata_q;
  logic [AW-1:0]  raddr;
  logic           mem_we;
  knot_t          wdata;

  logic [CNTW-1:0] knot_count_q;
  logic [CNTW-1:0] pos_q, j_q, j_d;
  logic [CNTW-1:0] n_act, n_m1, j_clamp, rd_idx;

  logic signed [QW-1:0]    q_q;
  knot_t                   lo_q;
  logic [QW-1:0]           den_q, dq_q;
  logic signed [VW:0]      dx_q;
  logic signed [PRODW-1:0] prod_q;
  logic                    neg_q;
  logic [QW-1:0]           rem_q;
  logic [VW-1:0]           quo_q;

  logic signed [VW-1:0] res_value_q;
  logic                 res_missing_q, res_status_q;
  logic                 out_valid_q;
  logic signed [VW-1:0] out_value_q;
  logic                 out_missing_q, out_status_q;

  logic signed [QW:0]   den_diff, dq_diff;
  logic [DVDW-1:0]      mag, dvd;
  logic [QW:0]          trial;
  logic                 trial_ge;
  logic signed [VW-1:0] res_value_d;
  logic signed [VW-1:0] div_value;

  // Active knot count clamped to 2..MAX_KNOTS
  always_comb begin
    n_act = knot_count_q;
    if (n_act < CNTW'(2)) begin
      n_act = CNTW'(2);
    end
    if ({25'd0, knot_count_q} > 32'(MAX_KNOTS)) begin
      n_act = CNTW'(MAX_KNOTS);
    end
    n_m1 = n_act - 1'b1;
  end

  // Remembered position clamped into 1..count-1
  always_comb begin
    j_clamp = pos_q;
    if (pos_q < CNTW'(1)) begin
      j_clamp = CNTW'(1);
    end else if (pos_q > n_m1) begin
      j_clamp = n_m1;
    end
  end

  // Search index update
  always_comb begin
    case (cmd_i.j_op)
      J_HOLD:  j_d = j_q;
      J_CLAMP: j_d = j_clamp;
      J_DEC:   j_d = j_q - 1'b1;
      J_INC:   j_d = j_q + 1'b1;
      default: j_d = j_q;
    endcase
  end

  // Read address
  always_comb begin
    case (cmd_i.rd_sel)
      RD_ZERO:  rd_idx = '0;
      RD_LAST:  rd_idx = n_m1;
      RD_JD_M1: rd_idx = j_d - 1'b1;
      RD_JD:    rd_idx = j_d;
      default:  rd_idx = '0;
    endcase
    raddr = AW'(rd_idx);
  end

  assign mem_we = cmd_i.mem_wr && ({26'd0, knot_index_i} < 32'(MAX_KNOTS));
  assign wdata  = '{quantile: knot_quantile_i, value: knot_value_i};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[AW'(knot_index_i)] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  // Segment differences against the lower knot
  assign den_diff = {rdata_q.quantile[QW-1], rdata_q.quantile}
                  - {lo_q.quantile[QW-1], lo_q.quantile};
  assign dq_diff  = {q_q[QW-1], q_q} - {lo_q.quantile[QW-1], lo_q.quantile};

  // Status to the controller
  always_comb begin
    stat_o.q_le     = (q_q <= rdata_q.quantile);
    stat_o.q_lt     = (q_q < rdata_q.quantile);
    stat_o.j_one    = (j_q == CNTW'(1));
    stat_o.j_last   = (j_q == n_m1);
    stat_o.den_pos  = !den_diff[QW] && (den_diff != '0);
    stat_o.out_free = !out_valid_q || !out_stall_i;
  end

  // Rounded dividend: |num| + den/2, halves away from zero
  assign mag = prod_q[PRODW-1] ? DVDW'(-prod_q) : DVDW'(prod_q);
  assign dvd = mag + DVDW'(den_q >> 1);

  // One restoring divide step
  assign trial    = {rem_q, quo_q[VW-1]};
  assign trial_ge = (trial >= {1'b0, den_q});

  assign div_value = lo_q.value + (neg_q ? -$signed(quo_q) : $signed(quo_q));

  // Result selection
  always_comb begin
    case (cmd_i.res_op)
      RES_RDATA: res_value_d = rdata_q.value;
      RES_LO:    res_value_d = lo_q.value;
      RES_DIV:   res_value_d = div_value;
      default:   res_value_d = '0;
    endcase
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.query_load) begin
      q_q <= query_quantile_i;
    end
    if (cmd_i.lo_load) begin
      lo_q <= rdata_q;
    end
    if (cmd_i.seg_load) begin
      den_q <= den_diff[QW-1:0];
      dq_q  <= dq_diff[QW-1:0];
      dx_q  <= {rdata_q.value[VW-1], rdata_q.value} - {lo_q.value[VW-1], lo_q.value};
    end
    if (cmd_i.mul_load) begin
      prod_q <= PRODW'($signed({1'b0, dq_q}) * dx_q);
    end
    if (cmd_i.div_init) begin
      neg_q <= prod_q[PRODW-1];
      rem_q <= dvd[DVDW-1:VW];
      quo_q <= dvd[VW-1:0];
    end else if (cmd_i.div_step) begin
      rem_q <= trial_ge ? QW'(trial - {1'b0, den_q}) : trial[QW-1:0];
      quo_q <= {quo_q[VW-2:0], trial_ge};
    end
    if (cmd_i.res_op != RES_NONE) begin
      res_value_q   <= res_value_d;
      res_missing_q <= (cmd_i.res_op == RES_MISS);
      res_status_q  <= (cmd_i.res_op == RES_FAIL);
    end
    if (cmd_i.out_load) begin
      out_value_q   <= res_value_q;
      out_missing_q <= res_missing_q;
      out_status_q  <= res_status_q;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      knot_count_q <= CNTW'(2);
      pos_q        <= CNTW'(1);
      j_q          <= CNTW'(1);
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        knot_count_q <= cfg_wdata_i;
      end
      j_q <= j_d;
      if (cmd_i.pos_load) begin
        pos_q <= j_d;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_value_o   = out_value_q;
  assign result_missing_o = out_missing_q;
  assign status_o         = out_status_q;

endmodule

`default_nettype wire
